>>> design/disc_pkg.sv
// ----------------------------------------------------------------------------
// disc_pkg: shared constants and helpers for the disjoint id set check
// status codes, parameter defaults and the bit length helper
// ----------------------------------------------------------------------------
package disc_pkg;

  localparam int MAX_IDS_DEF      = 256;
  localparam int BITMAP_WORDS_DEF = 128;
  localparam int WORD_BITS        = 32;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_DISJOINT  = 2'd0;
  localparam status_t STATUS_DUPLICATE = 2'd1;
  localparam status_t STATUS_TOO_MANY  = 2'd2;
  localparam status_t STATUS_TOO_SMALL = 2'd3;

  // number of significant bits, 0 for a zero value
  function automatic logic [5:0] bit_length(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

>>> design/disjoint_id_set_check.sv
// ----------------------------------------------------------------------------
// disjoint_id_set_check: bitmap based disjointness check of two id sets
//
// input channel (in_valid/in_ready) carries one word per id: the 64-bit id,
// its group (0 = first set, 1 = second set) and a last flag. ids are stored
// in an id ram at one word per cycle while the largest low half is tracked.
// the word marked last starts the check; in_ready stays low until the result
// has been placed in the output register.
// the check runs a setup step, a range pass over the stored ids, a clear
// sweep of the bitmap, a mark pass and a check pass; each id visit reads
// the id ram, compacts the id and acts on it, with a bitmap write-back for
// first-set ids when marking and second-set ids when checking; too many ids
// goes from setup to the result, and bitmap too small stops early
// the passes are bound by the single read port of the id ram and the
// read-modify-write of the bitmap ram, one entry in flight at a time.
// output channel (out_valid/out_ready) carries one status/dup_id word per
// load. the output register holds it while the receiver stalls; a new load
// is taken meanwhile, and its result waits until the register is free.
// reset returns to loading with an empty store; ram contents are not reset.
// ----------------------------------------------------------------------------
module disjoint_id_set_check #(
  parameter int MAX_IDS      = disc_pkg::MAX_IDS_DEF,
  parameter int BITMAP_WORDS = disc_pkg::BITMAP_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        id,
  input  logic               group,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output disc_pkg::status_t  status,
  output logic [63:0]        dup_id
);

  import disc_pkg::*;

  localparam int AW  = $clog2(MAX_IDS);
  localparam int CW  = $clog2(MAX_IDS + 1);
  localparam int BAW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [63:0] LIMIT = 64'(BITMAP_WORDS * WORD_BITS);

  // sequencer states
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CMPT  = 3'd3;
  localparam logic [2:0] ST_ACT   = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;
  localparam logic [2:0] ST_CLEAR = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // pass over the stored ids
  localparam logic [1:0] PASS_RANGE = 2'd0;
  localparam logic [1:0] PASS_MARK  = 2'd1;
  localparam logic [1:0] PASS_CHECK = 2'd2;

  logic [2:0]     state;
  logic [1:0]     pass;
  logic [CW-1:0]  item_count;
  logic           overflow_seen;
  logic [31:0]    max_low_half;
  logic [5:0]     k;
  logic [AW-1:0]  idx;
  logic [BAW-1:0] clr;
  logic           cur_group;
  logic [63:0]    cur_id;
  status_t        res_status;
  logic [63:0]    res_dup;

  logic           accept;
  logic           store_ok;
  logic           last_idx;
  logic           res_load;
  logic [64:0]    id_rdata;
  logic [63:0]    compact;
  logic [BAW-1:0] word_addr;
  logic [31:0]    bm_rdata;
  logic [31:0]    bit_mask;
  logic           bit_hit;
  logic           bm_we;
  logic [BAW-1:0] bm_waddr;
  logic [31:0]    bm_wdata;

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign store_ok = (item_count != CW'(MAX_IDS));
  assign last_idx = ((CW'(idx) + CW'(1)) == item_count);
  // verdict moves into the output register
  assign res_load = (state == ST_DONE) && (!out_valid || out_ready);

  // id store: id in the low bits, group on top
  disc_ram #(
    .WIDTH (65),
    .DEPTH (MAX_IDS),
    .AW    (AW)
  ) u_id_ram (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (item_count[AW-1:0]),
    .wdata ({group, id}),
    .re    (state == ST_RD),
    .raddr (idx),
    .rdata (id_rdata)
  );

  disc_compact u_compact (
    .clk     (clk),
    .load    (state == ST_CMPT),
    .id      (id_rdata[63:0]),
    .k       (k),
    .compact (compact)
  );

  // word index; the range pass guarantees compact < LIMIT here
  assign word_addr = compact[5 +: BAW];
  assign bit_mask  = 32'd1 << compact[4:0];
  assign bit_hit   = |(bm_rdata & bit_mask);

  // bitmap write: zero during the clear sweep, set bit on write-back
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = word_addr;
    bm_wdata = bm_rdata | bit_mask;
    if (state == ST_CLEAR) begin
      bm_we    = 1'b1;
      bm_waddr = clr;
      bm_wdata = 32'd0;
    end else if (state == ST_WB) begin
      bm_we = !(pass == PASS_CHECK && bit_hit);
    end
  end

  disc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS),
    .AW    (BAW)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (state == ST_ACT),
    .raddr (word_addr),
    .rdata (bm_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      pass          <= PASS_RANGE;
      item_count    <= '0;
      overflow_seen <= 1'b0;
      max_low_half  <= 32'd0;
      idx           <= '0;
      clr           <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              item_count <= item_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (id[31:0] > max_low_half) begin
              max_low_half <= id[31:0];
            end
            if (last) begin
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          k    <= bit_length(max_low_half);
          idx  <= '0;
          pass <= PASS_RANGE;
          res_dup <= 64'd0;
          if (overflow_seen) begin
            res_status <= STATUS_TOO_MANY;
            state      <= ST_DONE;
          end else begin
            res_status <= STATUS_DISJOINT;
            state      <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CMPT;
        end
        ST_CMPT: begin
          cur_id    <= id_rdata[63:0];
          cur_group <= id_rdata[64];
          state     <= ST_ACT;
        end
        ST_ACT: begin
          if (pass == PASS_RANGE && compact >= LIMIT) begin
            res_status <= STATUS_TOO_SMALL;
            state      <= ST_DONE;
          end else if ((pass == PASS_MARK && !cur_group) ||
                       (pass == PASS_CHECK && cur_group)) begin
            state <= ST_WB;
          end else if (!last_idx) begin
            idx   <= idx + AW'(1);
            state <= ST_RD;
          end else begin
            idx <= '0;
            case (pass)
              PASS_RANGE: begin
                clr   <= '0;
                state <= ST_CLEAR;
              end
              PASS_MARK: begin
                pass  <= PASS_CHECK;
                state <= ST_RD;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_WB: begin
          if (pass == PASS_CHECK && bit_hit) begin
            res_status <= STATUS_DUPLICATE;
            res_dup    <= cur_id;
            state      <= ST_DONE;
          end else if (!last_idx) begin
            idx   <= idx + AW'(1);
            state <= ST_RD;
          end else begin
            idx <= '0;
            if (pass == PASS_MARK) begin
              pass  <= PASS_CHECK;
              state <= ST_RD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_CLEAR: begin
          // sweep zeros through the bitmap, then start marking
          clr <= clr + BAW'(1);
          if (clr == BAW'(BITMAP_WORDS - 1)) begin
            pass  <= PASS_MARK;
            idx   <= '0;
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          // wait for a free output register, then start a new load
          if (res_load) begin
            item_count    <= '0;
            overflow_seen <= 1'b0;
            max_low_half  <= 32'd0;
            state         <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output register valid: set when a verdict is placed, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= res_status;
      dup_id <= res_dup;
    end
  end

endmodule

>>> design/disc_ram.sv
// ----------------------------------------------------------------------------
// disc_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module disc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/disc_compact.sv
// ----------------------------------------------------------------------------
// disc_compact: registered id compaction
// forms (high half << k) + low half, modulo 2^64
// ----------------------------------------------------------------------------
module disc_compact (
  input  logic        clk,
  input  logic        load,
  input  logic [63:0] id,
  input  logic [5:0]  k,
  output logic [63:0] compact
);

  logic [63:0] high_shifted;

  assign high_shifted = {32'b0, id[63:32]} << k;

  always_ff @(posedge clk) begin
    if (load) begin
      compact <= high_shifted + {32'b0, id[31:0]};
    end
  end

endmodule

>>> tb/sv/tb_disjoint_id_set_check.sv
// ----------------------------------------------------------------------------
// tb_disjoint_id_set_check: self-checking bench for the disjoint id set check
//
// a queue of id words (short directed loads, then random loads) feeds a
// valid/ready driver; every accepted word goes through a behavioral copy of
// the check, which predicts one verdict per load. a monitor compares every
// accepted status/dup_id word against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module tb_disjoint_id_set_check;

  import disc_pkg::*;

  localparam int STORE_DEPTH = MAX_IDS_DEF;
  localparam int MAP_BITS    = BITMAP_WORDS_DEF * WORD_BITS;
  localparam int CYCLE_LIMIT = 400000;
  // the tail covers a full store of ids plus the bitmap clear
  localparam int TAIL_CYCLES = 3200;
  localparam int CALM_WORDS  = 40;

  // one word of the input channel, plus a flag that makes the sender
  // wait until every predicted verdict has come back
  typedef struct {
    logic [63:0] id;
    logic        grp;
    logic        last;
    bit          hold;
  } id_word_t;

  typedef struct {
    status_t     status;
    logic [63:0] dup;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] id = 64'h0;
  logic        group = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_t     status;
  logic [63:0] dup_id;

  disjoint_id_set_check dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .id        (id),
    .group     (group),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .dup_id    (dup_id)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // words still to send, and verdicts predicted but not yet seen
  id_word_t pending_ids[$];
  verdict_t verdict_q[$];
  int       bad_count = 0;
  int       cycles = 0;

  // ---------------------------------------------------------------------------
  // behavioral copy of the check
  // ---------------------------------------------------------------------------
  logic [63:0] load_ids [0:STORE_DEPTH-1];
  logic        load_grp [0:STORE_DEPTH-1];
  int          load_count = 0;
  bit          load_overflow = 1'b0;
  logic [31:0] load_max_low = 32'h0;
  bit          seen_bits [0:MAP_BITS-1];

  // table id shifted up by k, local id added below it
  function automatic logic [63:0] squeeze(input logic [63:0] v, input int k);
    return ({32'h0, v[63:32]} << k) + {32'h0, v[31:0]};
  endfunction

  // take one accepted word; on the last word of a load, predict the verdict
  task automatic track_id_word(input logic [63:0] wid, input logic wgrp,
                               input logic wlast);
    int          k;
    logic [31:0] v;
    logic [63:0] c;
    verdict_t    vd;
    bit          stop;
    if (load_count < STORE_DEPTH) begin
      load_ids[load_count] = wid;
      load_grp[load_count] = wgrp;
      load_count++;
    end else begin
      load_overflow = 1'b1;
    end
    if (wid[31:0] > load_max_low) begin
      load_max_low = wid[31:0];
    end
    if (wlast) begin
      // k is the bit length of the largest local id, 0 when all are zero
      k = 0;
      v = load_max_low;
      while (v != 32'h0) begin
        k++;
        v = v >> 1;
      end
      vd.status = STATUS_DISJOINT;
      vd.dup = 64'h0;
      // priority: too many ids, then bitmap too small, then duplicates
      if (load_overflow) begin
        vd.status = STATUS_TOO_MANY;
      end else begin
        for (int i = 0; i < load_count; i++) begin
          if (squeeze(load_ids[i], k) >= 64'(MAP_BITS)) begin
            vd.status = STATUS_TOO_SMALL;
          end
        end
      end
      if (vd.status == STATUS_DISJOINT) begin
        for (int i = 0; i < MAP_BITS; i++) begin
          seen_bits[i] = 1'b0;
        end
        // mark every first-set id
        for (int i = 0; i < load_count; i++) begin
          if (!load_grp[i]) begin
            c = squeeze(load_ids[i], k);
            seen_bits[c % MAP_BITS] = 1'b1;
          end
        end
        // walk second-set ids in arrival order, each marking its own bit,
        // so repeats inside the second set are caught as well
        stop = 1'b0;
        for (int i = 0; i < load_count && !stop; i++) begin
          if (load_grp[i]) begin
            c = squeeze(load_ids[i], k);
            if (seen_bits[c % MAP_BITS]) begin
              vd.status = STATUS_DUPLICATE;
              vd.dup = load_ids[i];
              stop = 1'b1;
            end else begin
              seen_bits[c % MAP_BITS] = 1'b1;
            end
          end
        end
      end
      verdict_q.push_back(vd);
      load_count = 0;
      load_overflow = 1'b0;
      load_max_low = 32'h0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [63:0] wid, input logic wgrp,
                           input logic wlast, input bit whold);
    id_word_t w;
    w.id = wid;
    w.grp = wgrp;
    w.last = wlast;
    w.hold = whold;
    pending_ids.push_back(w);
  endtask

  // random load of n ids; local ids are kept below 2**kmax and table ids
  // small enough that most loads fit the bitmap, with repeats mixed in
  task automatic make_load(input int n, input bit hold_first);
    int          kmax;
    int          rep_pct;
    logic [31:0] lo_cap;
    logic [31:0] hi_cap;
    logic [63:0] picked[$];
    logic [63:0] w;
    bit          wild;
    kmax = $urandom_range(0, 12);
    lo_cap = (32'h1 << kmax) - 32'h1;
    // now and then allow table ids a little past the bitmap edge
    if ($urandom_range(0, 9) == 0) begin
      hi_cap = 32'(8192 >> kmax);
    end else begin
      hi_cap = 32'(4096 >> kmax) - 32'h1;
    end
    rep_pct = $urandom_range(0, 45);
    wild = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if (picked.size() > 0 && $urandom_range(0, 99) < rep_pct) begin
        w = picked[$urandom_range(0, picked.size() - 1)];
      end else if (wild && $urandom_range(0, n - 1) == 0) begin
        w = {$urandom, $urandom};
      end else begin
        w = {32'($urandom_range(0, hi_cap)), 32'($urandom_range(0, lo_cap))};
      end
      picked.push_back(w);
      push_word(w, 1'($urandom_range(0, 1)), (i == n - 1), hold_first && (i == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  id_word_t nxt;
  int       in_gap = 0;
  int       in_idle_pct = 20;
  int       sent_words = 0;
  bit       calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_id_word(id, group, last);
      end
      calm <= (pending_ids.size() < CALM_WORDS);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_ids.size() == 0 ||
                     (pending_ids[0].hold && verdict_q.size() != 0)) begin
          // nothing left, or holding off until the block has answered
          in_valid <= 1'b0;
        end else begin
          nxt = pending_ids.pop_front();
          id <= nxt.id;
          group <= nxt.grp;
          last <= nxt.last;
          in_valid <= 1'b1;
          sent_words <= sent_words + 1;
          // idle burst after this word, rate changes every 32 words
          if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
            in_gap <= $urandom_range(1, 5);
          end
          if (sent_words % 32 == 31) begin
            case ($urandom_range(0, 2))
              0: begin
                in_idle_pct <= 0;
              end
              1: begin
                in_idle_pct <= 15;
              end
              default: begin
                in_idle_pct <= 45;
              end
            endcase
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready with random stall bursts, none in the last part
  // ---------------------------------------------------------------------------
  int out_stall = 0;
  int out_stall_pct = 25;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
          out_stall <= $urandom_range(1, 5);
        end
      end
      if ($urandom_range(0, 63) == 0) begin
        out_stall_pct <= ($urandom_range(0, 1) == 0) ? 0 : 40;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each accepted result word with the oldest verdict
  // ---------------------------------------------------------------------------
  verdict_t got;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("unexpected result word: status %0d dup_id %h", status, dup_id);
        end
      end else begin
        got = verdict_q.pop_front();
        if (status !== got.status || dup_id !== got.dup) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("mismatch: status exp %0d got %0d, dup_id exp %h got %h",
                     got.status, status, got.dup, dup_id);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** disjoint_id_set_check: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  int rnd_words;
  int n;

  initial begin
    // single zero id, all local ids zero so k is 0
    push_word(64'h0, 1'b0, 1'b1, 1'b0);
    // all-ones id: k becomes 32 and the compacted id is far past the bitmap
    push_word(64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b0);
    // plain cross-set duplicate, sent once the block is idle
    push_word(64'd5, 1'b0, 1'b0, 1'b1);
    push_word(64'd5, 1'b1, 1'b1, 1'b0);
    // repeat inside the second set only
    push_word(64'd7, 1'b1, 1'b0, 1'b0);
    push_word(64'd3, 1'b1, 1'b0, 1'b0);
    push_word(64'd7, 1'b1, 1'b1, 1'b0);
    // zero maximum with nonzero table ids: compacted ids are the table ids
    push_word({32'd3, 32'd0}, 1'b0, 1'b0, 1'b0);
    push_word({32'd1, 32'd0}, 1'b1, 1'b0, 1'b0);
    push_word({32'd3, 32'd0}, 1'b1, 1'b1, 1'b0);
    // top bit of the bitmap still fits
    push_word({32'd4095, 32'd0}, 1'b0, 1'b1, 1'b0);
    // one past the bitmap
    push_word({32'd4096, 32'd0}, 1'b1, 1'b1, 1'b0);
    // all-ones table id with zero local id
    push_word({32'hffff_ffff, 32'd0}, 1'b0, 1'b1, 1'b0);
    // bitmap too small wins over a duplicate in the same load
    push_word(64'd9, 1'b0, 1'b0, 1'b0);
    push_word(64'd9, 1'b1, 1'b0, 1'b0);
    push_word({32'd4096, 32'd0}, 1'b0, 1'b1, 1'b0);
    // disjoint second set only, nonzero k
    push_word(64'd1, 1'b1, 1'b0, 1'b0);
    push_word(64'd2, 1'b1, 1'b1, 1'b0);

    // random loads, mostly short
    rnd_words = 0;
    while (rnd_words < 250) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(9, 40);
      end else begin
        n = $urandom_range(1, 8);
      end
      make_load(n, ($urandom_range(0, 7) == 0));
      rnd_words += n;
    end
    // overflow of the id store, then short loads to see the store reset
    make_load($urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4), 1'b1);
    for (int i = 0; i < 5; i++) begin
      make_load($urandom_range(1, 8), 1'b0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent and every verdict back
    do begin
      @(negedge clk);
    end while (pending_ids.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (bad_count == 0 && verdict_q.size() == 0) begin
      $display("** disjoint_id_set_check: PASSED **");
    end else begin
      $display("** disjoint_id_set_check: FAILED **");
    end
    $finish;
  end

endmodule
